[hdl/fmle_pkg.sv]
`timescale 1ns / 1ps
// Package for the Fenwick prefix-maximum LIS engine.
// Holds tree geometry, field widths, sequencer states and control bundles.
// No dependencies.
package fmle_pkg;

  localparam int TREE_SIZE = 1024;
  localparam int VAL_W     = 10;
  localparam int LEN_W     = 11;
  localparam int ADDR_W    = $clog2(TREE_SIZE);
  localparam int POS_W     = $clog2(TREE_SIZE + 1);
  localparam int EXT_W     = (VAL_W + 1 > POS_W + 1) ? VAL_W + 1 : POS_W + 1;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_LEN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_fire;
    logic start_new;
    logic clr_last;
    logic query_done;
    logic update_done;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic accepting;
    logic clearing;
    logic querying;
    logic len_calc;
    logic updating;
    logic finishing;
  } ctrl_t;

endpackage

[hdl/fmle_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fmle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/fmle_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the LIS engine: clear sweep, query walk, update walk, hand-off.
// Depends on fmle_pkg.
module fmle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  fmle_pkg::status_t status,
  output fmle_pkg::ctrl_t   ctrl
);

  import fmle_pkg::*;

  state_t state;
  state_t state_next;
  logic   clear_for_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clear_for_item <= 1'b0;
    end else begin
      state <= state_next;
      if (status.in_fire) begin
        clear_for_item <= status.start_new;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (status.clr_last) begin
                   state_next = clear_for_item ? ST_QUERY : ST_IDLE;
                 end
      ST_IDLE:   if (status.in_fire) begin
                   state_next = status.start_new ? ST_CLEAR : ST_QUERY;
                 end
      ST_QUERY:  if (status.query_done) begin
                   state_next = ST_LEN;
                 end
      ST_LEN:    state_next = ST_UPDATE;
      ST_UPDATE: if (status.update_done) begin
                   state_next = ST_DONE;
                 end
      ST_DONE:   if (status.out_free) begin
                   state_next = ST_IDLE;
                 end
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_CLEAR:  ctrl.clearing  = 1'b1;
      ST_IDLE:   ctrl.accepting = 1'b1;
      ST_QUERY:  ctrl.querying  = 1'b1;
      ST_LEN:    ctrl.len_calc  = 1'b1;
      ST_UPDATE: ctrl.updating  = 1'b1;
      ST_DONE:   ctrl.finishing = status.out_free;
      default:   ctrl = '0;
    endcase
  end

endmodule

[hdl/fenwick_max_lis_engine_unit.sv]
`timescale 1ns / 1ps
// Top level of the Fenwick prefix-maximum LIS engine.
// Depends on fmle_pkg, fmle_ram and fmle_ctrl.
//
// Feed one sample value per transaction; each returns the length of the
// longest strictly increasing subsequence ending at that value and the best
// length since the sequence started. A 1024-entry prefix-maximum tree sits in
// one RAM with one read and one write port, walked one node per cycle by a
// single shared comparator: the query visits one node per set bit of the
// value, the update one node per step up the tree, with the write of each
// node overlapping the read of the next. The two walks always add up to
// eleven nodes; a value of zero has an empty query walk. An item passes
// through the query walk, the length step, the update walk and the hand-off
// to the output register before the next item is accepted. A result still
// waiting in the output register holds the engine until it drains; the input
// is ready again once the result is handed to the output register. After
// reset, and after any item with start_new set, a clearing sweep writes zeros
// over the whole tree, one entry per cycle, before work goes on; input is not
// accepted meanwhile.
module fenwick_max_lis_engine_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fmle_pkg::VAL_W-1:0]  sample_value,
  input  logic                        start_new,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fmle_pkg::LEN_W-1:0]  length_here,
  output logic [fmle_pkg::LEN_W-1:0]  best_length
);

  import fmle_pkg::*;

  status_t status;
  ctrl_t   ctrl;

  logic              in_fire;
  logic [POS_W-1:0]  qpos;
  logic [EXT_W-1:0]  upos;
  logic [EXT_W-1:0]  value_ext;
  logic [LEN_W-1:0]  m;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  best;
  logic [ADDR_W-1:0] wb_addr;
  logic [ADDR_W-1:0] clr_addr;
  logic              pend;
  logic              upos_in;
  logic              clr_last;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [LEN_W-1:0]  rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [LEN_W-1:0]  wr_data;

  logic [LEN_W-1:0]  cmp_a;
  logic [LEN_W-1:0]  cmp_b;
  logic              cmp_gt;

  assign in_ready  = ctrl.accepting;
  assign in_fire   = in_valid && in_ready;
  assign value_ext = EXT_W'(sample_value);
  assign upos_in   = (upos != '0) && (upos <= EXT_W'(TREE_SIZE));
  assign clr_last  = (clr_addr == ADDR_W'(TREE_SIZE - 1));

  always_comb begin
    status             = '0;
    status.in_fire     = in_fire;
    status.start_new   = start_new;
    status.clr_last    = clr_last;
    status.query_done  = (qpos == '0) && !pend;
    status.update_done = !upos_in && !pend;
    status.out_free    = !out_valid || out_ready;
  end

  fmle_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Shared comparator: node vs. running max, new length vs. node, length vs. best.
  always_comb begin
    priority if (ctrl.querying) begin
      cmp_a = rd_data;
      cmp_b = m;
    end else if (ctrl.updating) begin
      cmp_a = len;
      cmp_b = rd_data;
    end else begin
      cmp_a = len;
      cmp_b = best;
    end
  end
  assign cmp_gt = cmp_a > cmp_b;

  // Tree port steering: clear sweep, query reads, update read-modify-writes.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ADDR_W'(upos - 1'b1);
    wr_en   = 1'b0;
    wr_addr = wb_addr;
    wr_data = len;
    priority if (ctrl.clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (ctrl.querying) begin
      rd_en   = (qpos != '0);
      rd_addr = ADDR_W'(qpos - 1'b1);
    end else if (ctrl.updating) begin
      rd_en   = upos_in;
      wr_en   = pend && cmp_gt;
    end
  end

  fmle_ram #(
    .WIDTH (LEN_W),
    .DEPTH (TREE_SIZE)
  ) u_tree (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      clr_addr  <= '0;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      // A read in flight means its data is compared in the next cycle.
      pend <= rd_en;
      if (ctrl.clearing) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
      end
      if (in_fire && start_new) begin
        best <= '0;
      end else if (ctrl.finishing && cmp_gt) begin
        best <= len;
      end
      if (ctrl.finishing) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      // Query runs over positions below the element's own; clamp to the tree.
      qpos <= (value_ext > EXT_W'(TREE_SIZE)) ? POS_W'(TREE_SIZE) : POS_W'(value_ext);
      upos <= value_ext + 1'b1;
      m    <= '0;
    end else begin
      if (ctrl.querying) begin
        if (qpos != '0) begin
          qpos <= qpos & (qpos - 1'b1);
        end
        if (pend && cmp_gt) begin
          m <= rd_data;
        end
      end
      if (ctrl.updating && upos_in) begin
        wb_addr <= rd_addr;
        upos    <= upos + (upos & (~upos + 1'b1));
      end
    end
    if (ctrl.len_calc) begin
      // Saturate at the top of the length field.
      len <= (m == LEN_MAX) ? m : m + 1'b1;
    end
    if (ctrl.finishing) begin
      length_here <= len;
      best_length <= cmp_gt ? len : best;
    end
  end

  // The tree is never written while the query walk reads it.
  assert property (@(posedge clk) disable iff (rst) !(ctrl.querying && wr_en))
    else $error("tree written during query walk");

  // Update writes and the next read never hit the same node.
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.updating && wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("update write collides with next read");

  // An item without a start flag goes straight into the query walk.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && !start_new) |=> ctrl.querying)
    else $error("query walk did not start");

  // A delivered result never has a best below its own length, nor a zero length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (best_length >= length_here) && (length_here != '0))
    else $error("result lengths inconsistent");

endmodule

[tb/fenwick_max_lis_engine_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for fenwick_max_lis_engine_unit: directed table, then
// random sequences scored against a prefix-maximum tree predictor.
// Depends on fmle_pkg and the engine RTL only.
module fenwick_max_lis_engine_unit_tb;
  import fmle_pkg::*;

  localparam int TOTAL_ITEMS = 700;
  localparam int IDLE_PCT    = 32;
  localparam int DIR_ROWS    = 25;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] best;
  } lis_result_t;

  // One directed row; known marks rows whose result is typed in by hand.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             start;
    logic             known;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] best;
  } dir_row_t;

  typedef enum int {
    GEN_UNIFORM,
    GEN_WINDOW,
    GEN_CLIMB
  } gen_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [VAL_W-1:0] sample_value = '0;
  logic             start_new = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [LEN_W-1:0] length_here;
  logic [LEN_W-1:0] best_length;

  // Predictor state: prefix-maximum tree at positions 1..TREE_SIZE and the
  // best length of the running sequence.
  logic [LEN_W-1:0] lis_tree [1:TREE_SIZE];
  logic [LEN_W-1:0] lis_best;

  lis_result_t lis_pending_q [$];
  int          err_cnt = 0;
  bit          quiet = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1023, 0, 1, 1, 1},   // first item after reset, no start flag
    '{0,    0, 1, 1, 1},
    '{0,    0, 1, 1, 1},   // equal value never extends
    '{1,    0, 1, 2, 2},
    '{1023, 0, 1, 3, 3},   // top value queries every position below its own
    '{1023, 0, 0, 0, 0},
    '{512,  1, 1, 1, 1},   // start flag clears tree and best
    '{513,  0, 1, 2, 2},
    '{511,  0, 1, 1, 2},
    '{1022, 0, 0, 0, 0},
    '{682,  1, 1, 1, 1},   // alternating bit patterns: odd update paths
    '{341,  0, 1, 1, 1},
    '{1023, 0, 1, 2, 2},
    '{0,    1, 1, 1, 1},
    '{1,    0, 1, 2, 2},
    '{2,    0, 0, 0, 0},
    '{3,    0, 0, 0, 0},
    '{4,    0, 0, 0, 0},
    '{5,    0, 0, 0, 0},
    '{6,    0, 0, 0, 0},
    '{7,    0, 0, 0, 0},
    '{8,    0, 0, 0, 0},
    '{1023, 1, 1, 1, 1},
    '{1023, 0, 1, 1, 1},
    '{0,    0, 1, 1, 1}
  };

  fenwick_max_lis_engine_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .start_new    (start_new),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .length_here  (length_here),
    .best_length  (best_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clear the tree and the best, as reset and a start flag do.
  function void clear_lis();
    for (int p = 1; p <= TREE_SIZE; p++) lis_tree[p] = '0;
    lis_best = '0;
  endfunction

  // Advance the predictor by one element and return its result.
  function lis_result_t advance_lis(input logic [VAL_W-1:0] v, input logic s);
    int unsigned p;
    int unsigned m;
    lis_result_t r;
    if (s) clear_lis();
    // Query strictly below the element's own position (v + 1).
    m = 0;
    p = v;
    if (p > TREE_SIZE) p = TREE_SIZE;
    while (p != 0) begin
      if (lis_tree[p] > m) m = lis_tree[p];
      p = p & (p - 1);
    end
    r.len = (m + 1 > LEN_MAX) ? LEN_MAX : LEN_W'(m + 1);
    // Raise the running maximum along the update path.
    p = v + 1;
    while (p != 0 && p <= TREE_SIZE) begin
      if (lis_tree[p] < r.len) lis_tree[p] = r.len;
      p = p + (p & (~p + 1));
    end
    if (r.len > lis_best) lis_best = r.len;
    r.best = lis_best;
    return r;
  endfunction

  // Present one element, hold it until accepted, then log its expectation.
  task automatic issue_sample(input logic [VAL_W-1:0] v, input logic s,
                              input logic known, input logic [LEN_W-1:0] k_len,
                              input logic [LEN_W-1:0] k_best);
    lis_result_t r;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= v;
    start_new    <= s;
    do @(posedge clk); while (!in_ready);
    r = advance_lis(v, s);
    if (known) begin
      r.len  = k_len;
      r.best = k_best;
    end
    lis_pending_q.push_back(r);
  endtask

  // Drop valid and hold off until every outstanding result has drained.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (lis_pending_q.size() != 0) @(posedge clk);
  endtask

  // Receiver side: stall at random except during the quiet stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Score each result transaction against the oldest expectation.
  always @(posedge clk) begin : score_results
    lis_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (lis_pending_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result length_here=%0d best_length=%0d",
                 $time, length_here, best_length);
      end else begin
        want = lis_pending_q.pop_front();
        if (length_here !== want.len) begin
          err_cnt++;
          $display("%0t: length_here expected %0d actual %0d",
                   $time, want.len, length_here);
        end
        if (best_length !== want.best) begin
          err_cnt++;
          $display("%0t: best_length expected %0d actual %0d",
                   $time, want.best, best_length);
        end
      end
    end
  end

  initial begin : stimulus
    int        sent;
    int        seq_len;
    int        base;
    int        cur;
    int        val;
    logic      brk;
    gen_mode_t mode;

    clear_lis();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table; the engine sweeps its tree after reset, so just wait.
    for (int i = 0; i < DIR_ROWS; i++) begin
      issue_sample(dir_rows[i].value, dir_rows[i].start, dir_rows[i].known,
                   dir_rows[i].len, dir_rows[i].best);
    end
    drain_results();
    sent = DIR_ROWS;

    // Random sequences: each opens with a start flag; a few break early.
    while (sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 5) == 0) drain_results();
      mode = gen_mode_t'($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) begin
        // Long climb to push lengths well up.
        seq_len = $urandom_range(100, 250);
        mode    = GEN_CLIMB;
      end else begin
        seq_len = $urandom_range(4, 60);
      end
      base = $urandom_range(0, 1008);
      cur  = $urandom_range(0, 200);
      for (int k = 0; k < seq_len && sent < TOTAL_ITEMS; k++) begin
        quiet = (sent >= 300 && sent < 420);
        case (mode)
          GEN_UNIFORM: begin
            val = $urandom_range(0, 1023);
          end
          GEN_WINDOW: begin
            val = base + $urandom_range(0, 15);
          end
          default: begin
            cur = cur + $urandom_range(0, 4);
            if (cur > 1023) cur = $urandom_range(0, 100);
            val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : cur;
          end
        endcase
        brk = (k == 0) || ($urandom_range(0, 99) < 3);
        issue_sample(VAL_W'(val), brk, 1'b0, '0, '0);
        sent++;
      end
    end
    quiet = 1'b0;

    // Wait out the tail, then give stray results time to show up.
    drain_results();
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS fenwick_max_lis_engine_unit");
    end else begin
      $display("FAIL fenwick_max_lis_engine_unit");
    end
    $finish;
  end

  // Cap the run well above the slowest legal run (a tree sweep on every item).
  initial begin
    #50_000_000;
    $display("FAIL fenwick_max_lis_engine_unit");
    $finish;
  end

endmodule
